/* hw/rtl/ssa_pkg.sv */
// ----------------------------------------------------------------------------
// Slab slot allocator package
// Shared sizes, word formats and sequencer states.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int MAX_PAGES          = 16;
    localparam int MAX_SLOTS_PER_PAGE = 64;
    localparam int TOTAL_SLOTS        = MAX_PAGES * MAX_SLOTS_PER_PAGE;
    localparam int PAGE_W             = $clog2(MAX_PAGES);
    localparam int SLOT_W             = $clog2(MAX_SLOTS_PER_PAGE);
    localparam int SLOT_NUM_W         = PAGE_W + SLOT_W;
    localparam int PAGE_PTR_W         = PAGE_W + 1;
    localparam int SLOT_PTR_W         = SLOT_NUM_W + 1;
    localparam int PAGE_CNT_W         = $clog2(MAX_PAGES + 1);
    localparam int USED_W             = $clog2(TOTAL_SLOTS + 1);
    localparam int SPP_W              = 7;
    localparam int OBJ_W              = 16;
    localparam int USAGE_W            = 26;
    localparam int PROD_W             = USED_W + OBJ_W;
    localparam int CFG_IDX_W          = 1;

    localparam logic [PAGE_PTR_W-1:0] NO_PAGE   = PAGE_PTR_W'(MAX_PAGES);
    localparam logic [SLOT_PTR_W-1:0] NO_SLOT   = SLOT_PTR_W'(TOTAL_SLOTS);
    localparam logic [USAGE_W-1:0]    USAGE_MAX = '1;
    localparam logic [SPP_W-1:0]      SPP_MAX   = SPP_W'(MAX_SLOTS_PER_PAGE);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_FIT   = 2'd2;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_OUT_OF_PAGES = 2'd1;
    localparam logic [1:0] ERR_ALREADY_FREE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE    = 1'd1;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [SLOT_NUM_W-1:0] slot_number;
    } in_word_t;

    typedef struct packed {
        logic                  ok;
        logic [SLOT_NUM_W-1:0] granted_slot;
        logic [1:0]            error_code;
        logic [USAGE_W-1:0]    usage_bytes;
        logic [PAGE_CNT_W-1:0] pages_in_use;
    } out_word_t;

    typedef struct packed {
        logic [SPP_W-1:0] slots_per_page;
        logic [OBJ_W-1:0] object_size;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACT_PUSH,
        ST_POP_RD,
        ST_POP_WR,
        ST_FREE_WR,
        ST_FIT_RD,
        ST_FIT_CHK,
        ST_FIT_SLOT,
        ST_FIT_MUL,
        ST_FIT_END,
        ST_RESP
    } state_t;

endpackage

/* hw/rtl/ssa_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ssa_core.sv */
// ----------------------------------------------------------------------------
// Slab slot allocator sequencer
// Free-list links and per-page in-use rows live in RAMs; a sequencer runs
// read-modify-write steps for alloc and free and walks pages for fit.
// ----------------------------------------------------------------------------
module ssa_core import ssa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  in_word_t cmd,
    output res_t     res,
    input  logic     res_take
);

    state_t state_reg, state_next;

    logic [SLOT_PTR_W-1:0] free_head_reg, free_head_next;
    logic [MAX_PAGES-1:0]  page_active_reg, page_active_next;
    logic [PAGE_PTR_W-1:0] page_link_reg [MAX_PAGES];
    logic                  plink_we;
    logic [PAGE_W-1:0]     plink_addr;
    logic [PAGE_PTR_W-1:0] plink_data;
    logic [PAGE_PTR_W-1:0] page_head_reg, page_head_next;
    logic [USAGE_W-1:0]    usage_reg, usage_next;
    logic [MAX_PAGES-1:0]  row_valid_reg, row_valid_next;

    logic [SLOT_NUM_W-1:0] sn_reg, sn_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [PAGE_PTR_W-1:0] p_reg, p_next;
    logic [PAGE_PTR_W-1:0] pnext_reg, pnext_next;
    logic [PAGE_PTR_W-1:0] new_head_reg, new_head_next;
    logic [PAGE_CNT_W-1:0] iter_reg, iter_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [MAX_SLOTS_PER_PAGE-1:0] row_reg, row_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  ok_reg, ok_next;
    logic [SLOT_NUM_W-1:0] granted_reg, granted_next;
    logic [1:0]            err_reg, err_next;

    logic                  link_we;
    logic [SLOT_NUM_W-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
    logic                  row_we;
    logic [PAGE_W-1:0]     row_waddr, row_raddr, row_raddr_reg;
    logic [MAX_SLOTS_PER_PAGE-1:0] row_wdata, row_rdata, row_eff;

    logic [SPP_W-1:0]      n_eff;
    logic                  free_empty;
    logic                  have_inactive;
    logic [PAGE_W-1:0]     low_inactive;
    logic [PAGE_CNT_W-1:0] page_count;
    logic [SLOT_NUM_W-1:0] head_slot;
    logic [SLOT_NUM_W-1:0] push_addr;
    logic                  accept;
    logic                  row_bit;
    logic [USAGE_W:0]      usage_sum;

    ssa_ram #(.WIDTH(SLOT_NUM_W), .DEPTH(TOTAL_SLOTS)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ssa_ram #(.WIDTH(MAX_SLOTS_PER_PAGE), .DEPTH(MAX_PAGES)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // A row that was never written since reset or page activation reads as all free.
    assign row_eff = row_valid_reg[row_raddr_reg] ? row_rdata : '0;

    always_comb begin
        if (cfg.slots_per_page == '0) begin
            n_eff = SPP_W'(1);
        end else if (cfg.slots_per_page > SPP_MAX) begin
            n_eff = SPP_MAX;
        end else begin
            n_eff = cfg.slots_per_page;
        end
    end

    assign free_empty = free_head_reg[SLOT_PTR_W-1];
    assign head_slot  = free_head_reg[SLOT_NUM_W-1:0];
    assign accept     = cmd_valid && cmd_ready;
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign usage_sum  = {1'b0, usage_reg} + (USAGE_W+1)'(cfg.object_size);

    always_comb begin
        have_inactive = 1'b0;
        low_inactive  = '0;
        for (int i = MAX_PAGES - 1; i >= 0; i--) begin
            if (!page_active_reg[i]) begin
                have_inactive = 1'b1;
                low_inactive  = PAGE_W'(i);
            end
        end
    end

    always_comb begin
        page_count = '0;
        for (int i = 0; i < MAX_PAGES; i++) begin
            page_count = page_count + PAGE_CNT_W'(page_active_reg[i]);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd.opcode)
                        OP_ALLOC: begin
                            if (!free_empty) begin
                                state_next = ST_POP_WR;
                            end else if (have_inactive) begin
                                state_next = ST_ACT_PUSH;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        OP_FREE:  state_next = ST_FREE_WR;
                        OP_FIT:   state_next = ST_FIT_RD;
                        default:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_ACT_PUSH: begin
                if ({1'b0, cnt_reg} == n_eff - SPP_W'(1)) begin
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD:  state_next = ST_POP_WR;
            ST_POP_WR:  state_next = ST_RESP;
            ST_FREE_WR: state_next = ST_RESP;
            ST_FIT_RD: begin
                if (iter_reg == PAGE_CNT_W'(MAX_PAGES) || p_reg == NO_PAGE) begin
                    state_next = ST_FIT_MUL;
                end else begin
                    state_next = ST_FIT_CHK;
                end
            end
            ST_FIT_CHK: begin
                state_next = (row_eff == '0) ? ST_FIT_RD : ST_FIT_SLOT;
            end
            ST_FIT_SLOT: begin
                if (cnt_reg == SLOT_W'(MAX_SLOTS_PER_PAGE - 1)) begin
                    state_next = ST_FIT_RD;
                end
            end
            ST_FIT_MUL: state_next = ST_FIT_END;
            ST_FIT_END: state_next = ST_RESP;
            ST_RESP: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        free_head_next   = free_head_reg;
        page_active_next = page_active_reg;
        page_head_next   = page_head_reg;
        usage_next       = usage_reg;
        row_valid_next   = row_valid_reg;
        sn_next          = sn_reg;
        cnt_next         = cnt_reg;
        p_next           = p_reg;
        pnext_next       = pnext_reg;
        new_head_next    = new_head_reg;
        iter_next        = iter_reg;
        used_next        = used_reg;
        row_next         = row_reg;
        prod_next        = prod_reg;
        ok_next          = ok_reg;
        granted_next     = granted_reg;
        err_next         = err_reg;
        plink_we         = 1'b0;
        plink_addr       = '0;
        plink_data       = '0;
        link_we          = 1'b0;
        link_waddr       = '0;
        link_wdata       = '0;
        link_raddr       = head_slot;
        row_we           = 1'b0;
        row_waddr        = '0;
        row_wdata        = '0;
        row_raddr        = head_slot[SLOT_NUM_W-1:SLOT_W];
        push_addr        = '0;
        row_bit          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sn_next      = cmd.slot_number;
                    ok_next      = 1'b0;
                    granted_next = '0;
                    err_next     = ERR_NONE;
                    unique case (cmd.opcode)
                        OP_ALLOC: begin
                            if (free_empty) begin
                                if (have_inactive) begin
                                    page_active_next[low_inactive] = 1'b1;
                                    row_valid_next[low_inactive]   = 1'b0;
                                    plink_we       = 1'b1;
                                    plink_addr     = low_inactive;
                                    plink_data     = page_head_reg;
                                    page_head_next = {1'b0, low_inactive};
                                    p_next         = {1'b0, low_inactive};
                                    cnt_next       = '0;
                                end else begin
                                    err_next = ERR_OUT_OF_PAGES;
                                end
                            end
                        end
                        OP_FREE: begin
                            row_raddr = cmd.slot_number[SLOT_NUM_W-1:SLOT_W];
                        end
                        OP_FIT: begin
                            free_head_next = NO_SLOT;
                            p_next         = page_head_reg;
                            new_head_next  = NO_PAGE;
                            iter_next      = '0;
                            used_next      = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ACT_PUSH: begin
                push_addr      = {p_reg[PAGE_W-1:0], cnt_reg};
                link_we        = 1'b1;
                link_waddr     = push_addr;
                link_wdata     = free_empty ? push_addr : head_slot;
                free_head_next = {1'b0, push_addr};
                cnt_next       = cnt_reg + SLOT_W'(1);
            end
            ST_POP_RD: begin
                // Read addresses default to the list head.
            end
            ST_POP_WR: begin
                // The last entry of the list links to itself.
                free_head_next = (link_rdata == head_slot) ? NO_SLOT : {1'b0, link_rdata};
                row_we    = 1'b1;
                row_waddr = head_slot[SLOT_NUM_W-1:SLOT_W];
                row_wdata = row_eff;
                row_wdata[head_slot[SLOT_W-1:0]] = 1'b1;
                row_valid_next[head_slot[SLOT_NUM_W-1:SLOT_W]] = 1'b1;
                usage_next   = usage_sum[USAGE_W] ? USAGE_MAX : usage_sum[USAGE_W-1:0];
                ok_next      = 1'b1;
                granted_next = head_slot;
            end
            ST_FREE_WR: begin
                row_bit = row_eff[sn_reg[SLOT_W-1:0]];
                if (row_bit) begin
                    row_we    = 1'b1;
                    row_waddr = sn_reg[SLOT_NUM_W-1:SLOT_W];
                    row_wdata = row_eff;
                    row_wdata[sn_reg[SLOT_W-1:0]] = 1'b0;
                    link_we        = 1'b1;
                    link_waddr     = sn_reg;
                    link_wdata     = free_empty ? sn_reg : head_slot;
                    free_head_next = {1'b0, sn_reg};
                    if (usage_reg > USAGE_W'(cfg.object_size)) begin
                        usage_next = usage_reg - USAGE_W'(cfg.object_size);
                    end else begin
                        usage_next = '0;
                    end
                    ok_next = 1'b1;
                end else begin
                    err_next = ERR_ALREADY_FREE;
                end
            end
            ST_FIT_RD: begin
                row_raddr  = p_reg[PAGE_W-1:0];
                pnext_next = page_link_reg[p_reg[PAGE_W-1:0]];
                cnt_next   = '0;
            end
            ST_FIT_CHK: begin
                if (row_eff == '0) begin
                    page_active_next[p_reg[PAGE_W-1:0]] = 1'b0;
                    p_next    = pnext_reg;
                    iter_next = iter_reg + PAGE_CNT_W'(1);
                end else begin
                    row_next = row_eff;
                end
            end
            ST_FIT_SLOT: begin
                push_addr = {p_reg[PAGE_W-1:0], cnt_reg};
                if (row_reg[cnt_reg]) begin
                    used_next = used_reg + USED_W'(1);
                end else if ({1'b0, cnt_reg} < n_eff) begin
                    link_we        = 1'b1;
                    link_waddr     = push_addr;
                    link_wdata     = free_empty ? push_addr : head_slot;
                    free_head_next = {1'b0, push_addr};
                end
                cnt_next = cnt_reg + SLOT_W'(1);
                if (cnt_reg == SLOT_W'(MAX_SLOTS_PER_PAGE - 1)) begin
                    plink_we      = 1'b1;
                    plink_addr    = p_reg[PAGE_W-1:0];
                    plink_data    = new_head_reg;
                    new_head_next = p_reg;
                    p_next        = pnext_reg;
                    iter_next     = iter_reg + PAGE_CNT_W'(1);
                end
            end
            ST_FIT_MUL: begin
                prod_next = PROD_W'(used_reg) * PROD_W'(cfg.object_size);
            end
            ST_FIT_END: begin
                page_head_next = new_head_reg;
                usage_next = (prod_reg > PROD_W'(USAGE_MAX)) ? USAGE_MAX
                                                             : prod_reg[USAGE_W-1:0];
                ok_next = 1'b1;
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.valid             = (state_reg == ST_RESP);
        res.word.ok           = ok_reg;
        res.word.granted_slot = granted_reg;
        res.word.error_code   = err_reg;
        res.word.usage_bytes  = usage_reg;
        res.word.pages_in_use = page_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            free_head_reg   <= NO_SLOT;
            page_active_reg <= '0;
            page_head_reg   <= NO_PAGE;
            usage_reg       <= '0;
            row_valid_reg   <= '0;
        end else begin
            state_reg       <= state_next;
            free_head_reg   <= free_head_next;
            page_active_reg <= page_active_next;
            page_head_reg   <= page_head_next;
            usage_reg       <= usage_next;
            row_valid_reg   <= row_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sn_reg        <= sn_next;
        cnt_reg       <= cnt_next;
        p_reg         <= p_next;
        pnext_reg     <= pnext_next;
        new_head_reg  <= new_head_next;
        iter_reg      <= iter_next;
        used_reg      <= used_next;
        row_reg       <= row_next;
        prod_reg      <= prod_next;
        ok_reg        <= ok_next;
        granted_reg   <= granted_next;
        err_reg       <= err_next;
        row_raddr_reg <= row_raddr;
        if (plink_we) begin
            page_link_reg[plink_addr] <= plink_data;
        end
    end

endmodule

/* hw/rtl/slab_slot_allocator.sv */
// ----------------------------------------------------------------------------
// Slab slot allocator
// LIFO slot allocator over a pool of pages, with page release on fit.
//
//   channel | direction | ports                        | word
//   --------+-----------+------------------------------+-----------
//   s_      | in        | s_valid s_ready s_data       | in_word_t
//   m_      | out       | m_valid m_ready m_data       | out_word_t
//   cfg_    | in        | cfg_we cfg_index cfg_wdata   | register
//
// Alloc with a nonempty free list and free pass through one write state
// (ST_POP_WR or ST_FREE_WR) to ST_RESP, where the result word is offered.
// Alloc that activates a page first pushes its slots, then reads the head.
// Fit checks each page (ST_FIT_RD, ST_FIT_CHK) and releases empty ones; a kept
// page walks all of its slot positions one per cycle before the next page.
// Reset is synchronous; in-use rows are marked empty by per-page valid bits.
// A new word is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module slab_slot_allocator import ssa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [OBJ_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data
);

    cfg_t      cfg_reg;
    res_t      res;
    logic      res_take;
    logic      m_valid_reg;
    out_word_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slots_per_page <= SPP_MAX;
            cfg_reg.object_size    <= OBJ_W'(16);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SLOTS_PER_PAGE: cfg_reg.slots_per_page <= cfg_wdata[SPP_W-1:0];
                REG_OBJECT_SIZE:    cfg_reg.object_size    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ssa_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd       (s_data),
        .res       (res),
        .res_take  (res_take)
    );

    assign res_take = res.valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_data_reg <= res.word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
